### sv/aere_pkg.sv
// shared types and constants of the allocation event record encoder
package aere_pkg;

  localparam int SEC_W   = 32;
  localparam int NS_W    = 30;
  localparam int TRACE_W = 30;
  localparam int HEAD_W  = 32;
  localparam int MAG_W   = 33;
  localparam int US_W    = 20;
  localparam int DSEC_W  = 34;
  localparam int DNS_W   = 31;

  localparam logic [31:0] NS_PER_SEC     = 32'd1000000000;
  localparam logic [31:0] TWO_NS_PER_SEC = 32'd2000000000;

  // floor(x / 1000) == (x * US_RECIP) >> US_SHIFT for every x below 2^30
  localparam logic [30:0] US_RECIP = 31'd1099511628;
  localparam int          US_SHIFT = 40;
  localparam int          PROD_W   = 61;

  localparam int APB_AW = 3;
  localparam logic REG_INIT_SEC = 1'b0;
  localparam logic REG_INIT_NS  = 1'b1;

  localparam int Q_AW    = 2;
  localparam int Q_DEPTH = 4;

  typedef struct packed {
    logic              sec_we;
    logic              ns_we;
    logic [SEC_W-1:0]  sec;
    logic [NS_W-1:0]   ns;
  } cfg_wr_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HEAD,
    ST_SECS,
    ST_MICROS,
    ST_SIZE
  } emit_state_t;

endpackage

### sv/alloc_event_record_encoder.sv
// top level: config registers, front pipeline, queue and byte emitter
// throughput: one byte per cycle while out_tready is high; a record is 7 to 19 bytes, so
//   the event rate is set by the single byte emitter at the output
// reset: synchronous, active low; clears pipeline, queue, emitter, start registers
//   and previous timestamp to zero, with no clearing pass
module alloc_event_record_encoder #(
  parameter int SIZE_BITS = 48
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // time_seconds, time_nanoseconds, trace_index, byte_count, zero pad (lsb first)
  input  logic [((92+SIZE_BITS+7)/8)*8-1:0] in_tdata,
  // is_free
  input  logic                        in_tuser,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // out_byte
  output logic [7:0]                  out_tdata,
  output logic                        out_tlast,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [aere_pkg::APB_AW-1:0] cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);

  localparam int IN_W    = ((92 + SIZE_BITS + 7) / 8) * 8;
  localparam int ENTRY_W = aere_pkg::HEAD_W + aere_pkg::MAG_W + aere_pkg::US_W + SIZE_BITS;

  logic [aere_pkg::SEC_W-1:0] init_sec_r;
  logic [aere_pkg::NS_W-1:0]  init_ns_r;
  logic                       cfg_we;
  aere_pkg::cfg_wr_t          cfg_wr;

  logic               q_push, q_full, q_pop, q_valid;
  logic [ENTRY_W-1:0] q_wr_data, q_rd_data;

  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  assign cfg_wr.sec_we = cfg_we && (cfg_paddr[2] == aere_pkg::REG_INIT_SEC);
  assign cfg_wr.ns_we  = cfg_we && (cfg_paddr[2] == aere_pkg::REG_INIT_NS);
  assign cfg_wr.sec    = cfg_pwdata;
  assign cfg_wr.ns     = cfg_pwdata[aere_pkg::NS_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_sec_r <= '0;
      init_ns_r  <= '0;
    end else begin
      if (cfg_wr.sec_we) init_sec_r <= cfg_wr.sec;
      if (cfg_wr.ns_we)  init_ns_r  <= cfg_wr.ns;
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == aere_pkg::REG_INIT_NS) ? {2'b00, init_ns_r}
                                                              : init_sec_r;

  aere_front #(
    .SIZE_BITS (SIZE_BITS),
    .IN_W      (IN_W),
    .ENTRY_W   (ENTRY_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_wr    (cfg_wr),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (q_wr_data)
  );

  aere_queue #(
    .WIDTH (ENTRY_W)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr_data),
    .full    (q_full),
    .pop     (q_pop),
    .valid   (q_valid),
    .rd_data (q_rd_data)
  );

  aere_emit #(
    .SIZE_BITS (SIZE_BITS),
    .ENTRY_W   (ENTRY_W)
  ) u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_entry    (q_rd_data),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

`ifndef SYNTHESIS
  a_reset_no_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output word valid right after reset");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> q_full)
    else $error("front stalled while queue has room");

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("emitter popped an empty queue");
`endif

endmodule

### sv/aere_front.sv
// front pipeline: timestamp delta, normalization, magnitude and microsecond scaling
module aere_front #(
  parameter int SIZE_BITS = 48,
  parameter int IN_W      = 144,
  parameter int ENTRY_W   = 133
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_W-1:0]       in_tdata,
  input  logic                  in_tuser,
  input  aere_pkg::cfg_wr_t     cfg_wr,
  input  logic                  q_full,
  output logic                  q_push,
  output logic [ENTRY_W-1:0]    q_entry
);

  localparam int NS_LO    = aere_pkg::SEC_W;
  localparam int TRACE_LO = NS_LO + aere_pkg::NS_W;
  localparam int SIZE_LO  = TRACE_LO + aere_pkg::TRACE_W;

  logic [aere_pkg::SEC_W-1:0]   in_sec;
  logic [aere_pkg::NS_W-1:0]    in_ns;
  logic [aere_pkg::TRACE_W-1:0] in_trace;
  logic [SIZE_BITS-1:0]         in_size;
  logic                         adv;

  logic [aere_pkg::SEC_W-1:0]   prev_sec_r;
  logic [aere_pkg::NS_W-1:0]    prev_ns_r;

  logic                         v1_r, v2_r, v3_r;
  logic [aere_pkg::DSEC_W-1:0]  dsec1_r;
  logic [aere_pkg::DNS_W-1:0]   dns1_r;
  logic [aere_pkg::TRACE_W-1:0] trace1_r, trace2_r;
  logic                         free1_r, free2_r;
  logic [SIZE_BITS-1:0]         size1_r, size2_r, size3_r;

  logic [aere_pkg::DSEC_W-1:0]  dsec2_r, dsec2_nxt;
  logic [aere_pkg::NS_W-1:0]    dns2_r, dns2_nxt;

  logic [aere_pkg::HEAD_W-1:0]  head3_r, head3_nxt;
  logic [aere_pkg::MAG_W-1:0]   mag3_r, mag3_nxt;
  logic [aere_pkg::PROD_W-1:0]  prod3_r, prod3_nxt;

  logic [31:0]                  dns_x, dns_p1, dns_p2, dns_m1;
  logic [2:0]                   adj;
  logic [aere_pkg::DSEC_W-1:0]  dsec_neg;

  assign in_sec   = in_tdata[aere_pkg::SEC_W-1:0];
  assign in_ns    = in_tdata[NS_LO +: aere_pkg::NS_W];
  assign in_trace = in_tdata[TRACE_LO +: aere_pkg::TRACE_W];
  assign in_size  = in_tdata[SIZE_LO +: SIZE_BITS];

  // whole pipeline moves unless the last stage is held by a full queue
  assign adv       = !v3_r || !q_full;
  assign in_tready = adv;
  assign q_push    = v3_r && !q_full;

  // previous timestamp follows every accepted word; config writes seed it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_sec_r <= '0;
      prev_ns_r  <= '0;
    end else if (in_tvalid && adv) begin
      prev_sec_r <= in_sec;
      prev_ns_r  <= in_ns;
    end else begin
      if (cfg_wr.sec_we) prev_sec_r <= cfg_wr.sec;
      if (cfg_wr.ns_we)  prev_ns_r  <= cfg_wr.ns;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // normalize the nanosecond difference into one second, moving the borrow
  always_comb begin
    dns_x  = {dns1_r[aere_pkg::DNS_W-1], dns1_r};
    dns_p1 = dns_x + aere_pkg::NS_PER_SEC;
    dns_p2 = dns_x + aere_pkg::TWO_NS_PER_SEC;
    dns_m1 = dns_x - aere_pkg::NS_PER_SEC;
    if (dns_x[31]) begin
      if (dns_p1[31]) begin
        dns2_nxt = dns_p2[aere_pkg::NS_W-1:0];
        adj      = 3'b110;
      end else begin
        dns2_nxt = dns_p1[aere_pkg::NS_W-1:0];
        adj      = 3'b111;
      end
    end else if (!dns_m1[31]) begin
      dns2_nxt = dns_m1[aere_pkg::NS_W-1:0];
      adj      = 3'b001;
    end else begin
      dns2_nxt = dns_x[aere_pkg::NS_W-1:0];
      adj      = 3'b000;
    end
    dsec2_nxt = dsec1_r + {{(aere_pkg::DSEC_W-3){adj[2]}}, adj};
  end

  always_comb begin
    dsec_neg  = ~dsec2_r + {{(aere_pkg::DSEC_W-1){1'b0}}, 1'b1};
    mag3_nxt  = dsec2_r[aere_pkg::DSEC_W-1] ? dsec_neg[aere_pkg::MAG_W-1:0]
                                            : dsec2_r[aere_pkg::MAG_W-1:0];
    head3_nxt = {dsec2_r[aere_pkg::DSEC_W-1], free2_r, trace2_r};
    prod3_nxt = {{(aere_pkg::PROD_W-aere_pkg::NS_W){1'b0}}, dns2_r} *
                {{(aere_pkg::PROD_W-31){1'b0}}, aere_pkg::US_RECIP};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dsec1_r  <= {2'b00, in_sec} - {2'b00, prev_sec_r};
      dns1_r   <= {1'b0, in_ns} - {1'b0, prev_ns_r};
      trace1_r <= in_trace;
      free1_r  <= in_tuser;
      size1_r  <= in_size;

      dsec2_r  <= dsec2_nxt;
      dns2_r   <= dns2_nxt;
      trace2_r <= trace1_r;
      free2_r  <= free1_r;
      size2_r  <= size1_r;

      head3_r  <= head3_nxt;
      mag3_r   <= mag3_nxt;
      prod3_r  <= prod3_nxt;
      size3_r  <= size2_r;
    end
  end

  assign q_entry = {size3_r, prod3_r[aere_pkg::US_SHIFT +: aere_pkg::US_W], mag3_r, head3_r};

endmodule

### sv/aere_queue.sv
// small register queue between the front pipeline and the byte emitter
module aere_queue #(
  parameter int WIDTH = 133
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] rd_data
);

  localparam int CW = aere_pkg::Q_AW + 1;

  logic [WIDTH-1:0]          mem_r [aere_pkg::Q_DEPTH];
  logic [aere_pkg::Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]             cnt_r, cnt_nxt;

  assign full    = cnt_r == CW'(aere_pkg::Q_DEPTH);
  assign valid   = cnt_r != '0;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + CW'(1);
      2'b01:   cnt_nxt = cnt_r - CW'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + aere_pkg::Q_AW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + aere_pkg::Q_AW'(1);
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_data;
  end

endmodule

### sv/aere_emit.sv
// byte emitter: head word msb first, then three varints, one byte per cycle while out_tready is high
module aere_emit #(
  parameter int SIZE_BITS = 48,
  parameter int ENTRY_W   = 133
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  logic [ENTRY_W-1:0] q_entry,
  output logic               q_pop,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [7:0]         out_tdata,
  output logic               out_tlast
);

  localparam int MAG_LO  = aere_pkg::HEAD_W;
  localparam int US_LO   = MAG_LO + aere_pkg::MAG_W;
  localparam int SIZE_LO = US_LO + aere_pkg::US_W;

  aere_pkg::emit_state_t state_r, state_nxt;

  logic [1:0]                  hcnt_r;
  logic [aere_pkg::HEAD_W-1:0] head_r;
  logic [aere_pkg::MAG_W-1:0]  mag_r;
  logic [aere_pkg::US_W-1:0]   us_r;
  logic [SIZE_BITS-1:0]        size_r;

  logic       out_valid_r;
  logic [7:0] out_data_r;
  logic       out_last_r;

  logic       gen, emit, phase_end, byte_last, more;
  logic [7:0] byte_val;

  assign gen = !out_valid_r || out_tready;

  always_comb begin
    emit      = 1'b0;
    phase_end = 1'b0;
    byte_last = 1'b0;
    more      = 1'b0;
    byte_val  = '0;
    case (state_r)
      aere_pkg::ST_HEAD: begin
        emit      = gen;
        byte_val  = head_r[aere_pkg::HEAD_W-1 -: 8];
        phase_end = hcnt_r == 2'd3;
      end
      aere_pkg::ST_SECS: begin
        emit      = gen;
        more      = |mag_r[aere_pkg::MAG_W-1:7];
        byte_val  = {more, mag_r[6:0]};
        phase_end = !more;
      end
      aere_pkg::ST_MICROS: begin
        emit      = gen;
        more      = |us_r[aere_pkg::US_W-1:7];
        byte_val  = {more, us_r[6:0]};
        phase_end = !more;
      end
      aere_pkg::ST_SIZE: begin
        emit      = gen;
        more      = |size_r[SIZE_BITS-1:7];
        byte_val  = {more, size_r[6:0]};
        phase_end = !more;
        byte_last = !more;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
    // next record is loaded while the last byte of this one goes out
    q_pop = q_valid && ((state_r == aere_pkg::ST_IDLE) ||
                        (state_r == aere_pkg::ST_SIZE && emit && phase_end));
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      aere_pkg::ST_IDLE:   if (q_pop) state_nxt = aere_pkg::ST_HEAD;
      aere_pkg::ST_HEAD:   if (emit && phase_end) state_nxt = aere_pkg::ST_SECS;
      aere_pkg::ST_SECS:   if (emit && phase_end) state_nxt = aere_pkg::ST_MICROS;
      aere_pkg::ST_MICROS: if (emit && phase_end) state_nxt = aere_pkg::ST_SIZE;
      aere_pkg::ST_SIZE: begin
        if (emit && phase_end) state_nxt = q_pop ? aere_pkg::ST_HEAD : aere_pkg::ST_IDLE;
      end
      default: state_nxt = aere_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= aere_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= byte_val;
      out_last_r <= byte_last;
    end
    if (q_pop) begin
      hcnt_r <= 2'd0;
      head_r <= q_entry[aere_pkg::HEAD_W-1:0];
      mag_r  <= q_entry[MAG_LO +: aere_pkg::MAG_W];
      us_r   <= q_entry[US_LO +: aere_pkg::US_W];
      size_r <= q_entry[SIZE_LO +: SIZE_BITS];
    end else if (emit) begin
      case (state_r)
        aere_pkg::ST_HEAD: begin
          hcnt_r <= hcnt_r + 2'd1;
          head_r <= {head_r[aere_pkg::HEAD_W-9:0], 8'h00};
        end
        aere_pkg::ST_SECS:   mag_r  <= {7'b0, mag_r[aere_pkg::MAG_W-1:7]};
        aere_pkg::ST_MICROS: us_r   <= {7'b0, us_r[aere_pkg::US_W-1:7]};
        aere_pkg::ST_SIZE:   size_r <= {7'b0, size_r[SIZE_BITS-1:7]};
        default:             hcnt_r <= hcnt_r;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule
